// ===== sv/sie_pkg.sv =====
package sie_pkg;

    localparam int WORD_W = 24;
    localparam int MEM_DEPTH_DEF = 1024;
    localparam int PROG_DEPTH_DEF = 1024;
    localparam int POS_W = 10;
    localparam logic [WORD_W-1:0] BYTE_MASK = 24'd255;

    typedef enum logic [4:0] {
        F_PRELOAD = 5'd0, F_ADD = 5'd1, F_SUB = 5'd2, F_MUL = 5'd3, F_DIV = 5'd4,
        F_AND = 5'd5, F_OR = 5'd6, F_LDA = 5'd7, F_LDCH = 5'd8, F_LDL = 5'd9,
        F_LDX = 5'd10, F_STA = 5'd11, F_STCH = 5'd12, F_STL = 5'd13, F_STX = 5'd14,
        F_COMP = 5'd15, F_TIX = 5'd16, F_J = 5'd17, F_JEQ = 5'd18, F_JGT = 5'd19,
        F_JLT = 5'd20, F_JSUB = 5'd21, F_RSUB = 5'd22
    } func_t;

    typedef enum logic [1:0] {
        ST_EQ = 2'd0, ST_GT = 2'd1, ST_LT = 2'd2
    } cc_t;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_DIV, S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic mem_read;
        logic exec;
        logic div_start;
        logic div_step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_div;
        logic div_zero;
        logic div_last;
    } sts_t;

endpackage

// ===== sv/sic_instruction_execute.sv =====
// channel | ports beside valid/ready                                        | direction
// s_      | func address operand_is_byte/_array preload_data position target | in
// m_      | acc/index/link/status_out next_position div_zero                 | out
// Each word passes through the read and execute states and then the output handshake;
// DIV with a non-zero operand adds a divide phase, one quotient bit per cycle in the divider.
// Reset (aresetn, synchronous) clears acc, X, L, status; data memory is not cleared.
// A stalled result holds the block; no new word is taken until it leaves.
module sic_instruction_execute #(
    parameter int MEM_DEPTH = sie_pkg::MEM_DEPTH_DEF,
    parameter int PROG_DEPTH = sie_pkg::PROG_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_func,
    input  logic [9:0]  s_address,
    input  logic        s_operand_is_byte,
    input  logic        s_operand_is_array,
    input  logic [23:0] s_preload_data,
    input  logic [9:0]  s_position,
    input  logic [9:0]  s_target,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_acc_out,
    output logic [23:0] m_index_out,
    output logic [23:0] m_link_out,
    output logic [1:0]  m_status_out,
    output logic [9:0]  m_next_position,
    output logic        m_div_zero
);
    import sie_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequence control
    sie_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .sts, .cmd
    );

    // registers, memory and divider
    sie_dpath #(.MEM_DEPTH(MEM_DEPTH), .PROG_DEPTH(PROG_DEPTH)) u_dpath (
        .aclk, .aresetn, .cmd, .sts, .s_func, .s_address, .s_operand_is_byte,
        .s_operand_is_array, .s_preload_data, .s_position, .s_target,
        .m_acc_out, .m_index_out, .m_link_out, .m_status_out,
        .m_next_position, .m_div_zero
    );
endmodule

// ===== sv/sie_ctrl.sv =====
module sie_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  sie_pkg::sts_t sts,
    output sie_pkg::cmd_t cmd
);
    import sie_pkg::*;

    state_t state_reg, state_next;

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequence one word through read, execute and optional divide
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.mem_read = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (sts.is_div && !sts.div_zero) begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end else begin
                    cmd.exec = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.mem_read, cmd.exec, cmd.div_start, cmd.div_step}))
        else $error("more than one command");
    a_cap_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> cmd.mem_read) else $error("read missing after capture");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
endmodule

// ===== sv/sie_dpath.sv =====
module sie_dpath #(
    parameter int MEM_DEPTH = sie_pkg::MEM_DEPTH_DEF,
    parameter int PROG_DEPTH = sie_pkg::PROG_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sie_pkg::cmd_t               cmd,
    output sie_pkg::sts_t               sts,
    input  logic [4:0]                  s_func,
    input  logic [9:0]                  s_address,
    input  logic                        s_operand_is_byte,
    input  logic                        s_operand_is_array,
    input  logic [23:0]                 s_preload_data,
    input  logic [9:0]                  s_position,
    input  logic [9:0]                  s_target,
    output logic [23:0]                 m_acc_out,
    output logic [23:0]                 m_index_out,
    output logic [23:0]                 m_link_out,
    output logic [1:0]                  m_status_out,
    output logic [9:0]                  m_next_position,
    output logic                        m_div_zero
);
    import sie_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int PW = $clog2(PROG_DEPTH);
    localparam int CW = $clog2(WORD_W + 1);

    logic [WORD_W-1:0] mem [MEM_DEPTH];

    logic [4:0]        func_reg;
    logic [AW-1:0]     ea_reg, base_reg;
    logic              byte_reg;
    logic [WORD_W-1:0] pre_reg, rd_reg;
    logic [PW-1:0]     pos1_reg, tgt_reg;
    logic [WORD_W-1:0] acc_reg, x_reg, l_reg;
    logic [1:0]        st_reg;
    logic [PW-1:0]     rp_reg, next_reg;
    logic              dz_reg;
    logic [WORD_W-1:0] q_reg, r_reg, d_reg;
    logic [CW-1:0]     cnt_reg;

    logic [WORD_W-1:0] mask, opnd, x1, acc_next;
    logic [2*WORD_W-1:0] prod;
    logic [WORD_W:0]   rem_sh, rem_sub;
    logic [AW-1:0]     ea_next;
    logic [PW-1:0]     pos_w;

    // effective address, wrapped to memory depth
    always_comb begin
        ea_next = AW'(AW'(s_address) + (s_operand_is_array ? x_reg[AW-1:0] : AW'(0)));
        pos_w = PW'(s_position + 10'd1);
    end

    // capture the word
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= s_func;
            ea_reg   <= ea_next;
            base_reg <= AW'(s_address);
            byte_reg <= s_operand_is_byte;
            pre_reg  <= s_preload_data;
            pos1_reg <= pos_w;
            tgt_reg  <= PW'(s_target);
        end
    end

    // memory read and write
    always_ff @(posedge aclk) begin
        if (cmd.mem_read) begin
            rd_reg <= mem[ea_reg];
        end
        if (cmd.exec) begin
            case (func_reg)
                F_PRELOAD: mem[base_reg] <= pre_reg;
                F_STA:     mem[ea_reg] <= acc_reg & mask;
                F_STCH:    mem[ea_reg] <= acc_reg & BYTE_MASK;
                F_STL:     mem[ea_reg] <= l_reg & mask;
                F_STX:     mem[ea_reg] <= x_reg & mask;
                default: ;
            endcase
        end
    end

    assign mask = byte_reg ? BYTE_MASK : '1;
    assign opnd = rd_reg & mask;
    assign x1   = x_reg + 24'd1;
    assign prod = acc_reg * opnd;
    assign rem_sh  = {r_reg, q_reg[WORD_W-1]};
    assign rem_sub = rem_sh - {1'b0, d_reg};

    assign sts.is_div   = (func_reg == F_DIV);
    assign sts.div_zero = (opnd == '0);
    assign sts.div_last = (cnt_reg == CW'(1));

    function automatic logic [1:0] cmp(input logic [WORD_W-1:0] a, b);
        if (a > b) return ST_GT;
        if (a < b) return ST_LT;
        return ST_EQ;
    endfunction

    // architectural registers and divider
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            x_reg   <= '0;
            l_reg   <= '0;
            st_reg  <= ST_EQ;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (cmd.div_start) begin
                q_reg   <= acc_reg;
                r_reg   <= '0;
                d_reg   <= opnd;
                cnt_reg <= CW'(WORD_W);
            end
            // shift-subtract one quotient bit
            if (cmd.div_step) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (!rem_sub[WORD_W]) begin
                    r_reg <= rem_sub[WORD_W-1:0];
                    q_reg <= {q_reg[WORD_W-2:0], 1'b1};
                end else begin
                    r_reg <= rem_sh[WORD_W-1:0];
                    q_reg <= {q_reg[WORD_W-2:0], 1'b0};
                end
                if (sts.div_last) begin
                    acc_reg  <= rem_sub[WORD_W] ? {q_reg[WORD_W-2:0], 1'b0}
                                                : {q_reg[WORD_W-2:0], 1'b1};
                    dz_reg   <= 1'b0;
                    next_reg <= pos1_reg;
                end
            end
            if (cmd.exec) begin
                dz_reg   <= 1'b0;
                next_reg <= pos1_reg;
                case (func_reg)
                    F_ADD:  acc_reg <= acc_reg + opnd;
                    F_SUB:  acc_reg <= acc_reg - opnd;
                    F_MUL:  acc_reg <= prod[WORD_W-1:0];
                    F_DIV:  dz_reg <= 1'b1;
                    F_AND:  acc_reg <= acc_reg & opnd;
                    F_OR:   acc_reg <= acc_reg | opnd;
                    F_LDA:  acc_reg <= opnd;
                    F_LDCH: acc_reg <= rd_reg & BYTE_MASK;
                    F_LDL:  l_reg <= opnd;
                    F_LDX:  x_reg <= opnd;
                    F_COMP: st_reg <= cmp(acc_reg, opnd);
                    F_TIX: begin
                        x_reg  <= x1;
                        st_reg <= cmp(x1, opnd);
                    end
                    F_J:    next_reg <= tgt_reg;
                    F_JEQ:  if (st_reg == ST_EQ) next_reg <= tgt_reg;
                    F_JGT:  if (st_reg == ST_GT) next_reg <= tgt_reg;
                    F_JLT:  if (st_reg == ST_LT) next_reg <= tgt_reg;
                    F_JSUB: begin
                        rp_reg   <= pos1_reg;
                        next_reg <= tgt_reg;
                    end
                    F_RSUB: next_reg <= rp_reg;
                    default: ;
                endcase
            end
        end
    end

    assign acc_next = acc_reg;
    assign m_acc_out = acc_next;
    assign m_index_out = x_reg;
    assign m_link_out = l_reg;
    assign m_status_out = st_reg;
    assign m_next_position = 10'(next_reg);
    assign m_div_zero = dz_reg;

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg != 2'd3) else $error("bad status code");
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> cnt_reg != '0) else $error("divide overrun");
    a_dz_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && func_reg == F_DIV |=> $stable(acc_reg)) else $error("acc changed");
endmodule
